// ===== design/msq_pkg.sv =====
package msq_pkg;

   localparam int MAX_GRID_WIDTH = 4096;
   localparam int FRAC_BITS      = 8;

   localparam int SAMPLE_W   = 16;
   localparam int GRID_W     = 13;
   localparam int ROW_W      = 13;
   localparam int COL_W      = $clog2(MAX_GRID_WIDTH);
   localparam int COORD_W    = 22;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(FRAC_BITS);
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 4 * COORD_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ROW_W-1:0]  ROW_MAX  = {ROW_W{1'b1}};

   // register index, taken from the word address
   localparam logic REG_LEVEL      = 1'b0;
   localparam logic REG_GRID_WIDTH = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic       nan;
      sample_type value;
   } corner_type;

   typedef struct packed {
      logic       start;
      sample_type a;
      sample_type b;
      sample_type lv;
   } div_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [FRAC_W-1:0] frac;
   } div_stat_type;

   // crossing points of a cell, also the order the edges are divided in
   typedef enum logic [1:0] {
      PT_TOP,
      PT_BOTTOM,
      PT_LEFT,
      PT_RIGHT
   } point_type;

   typedef struct packed {
      point_type from0;
      point_type to0;
      point_type from1;
      point_type to1;
   } seg_pts_type;

   function automatic logic [1:0] seg_count(input logic [3:0] sq);
      logic [1:0] n;
      if (sq == 4'd0 || sq == 4'd15) begin
         n = 2'd0;
      end else if (sq == 4'd6 || sq == 4'd9) begin
         n = 2'd2;
      end else begin
         n = 2'd1;
      end
      return n;
   endfunction

   function automatic seg_pts_type seg_table(input logic [3:0] sq);
      seg_pts_type p;
      unique case (sq)
         4'd1:    p = '{PT_TOP,    PT_LEFT,   PT_TOP,    PT_TOP};
         4'd2:    p = '{PT_RIGHT,  PT_TOP,    PT_TOP,    PT_TOP};
         4'd3:    p = '{PT_RIGHT,  PT_LEFT,   PT_TOP,    PT_TOP};
         4'd4:    p = '{PT_LEFT,   PT_BOTTOM, PT_TOP,    PT_TOP};
         4'd5:    p = '{PT_TOP,    PT_BOTTOM, PT_TOP,    PT_TOP};
         4'd6:    p = '{PT_RIGHT,  PT_TOP,    PT_LEFT,   PT_BOTTOM};
         4'd7:    p = '{PT_RIGHT,  PT_BOTTOM, PT_TOP,    PT_TOP};
         4'd8:    p = '{PT_BOTTOM, PT_RIGHT,  PT_TOP,    PT_TOP};
         4'd9:    p = '{PT_TOP,    PT_LEFT,   PT_BOTTOM, PT_RIGHT};
         4'd10:   p = '{PT_BOTTOM, PT_TOP,    PT_TOP,    PT_TOP};
         4'd11:   p = '{PT_BOTTOM, PT_LEFT,   PT_TOP,    PT_TOP};
         4'd12:   p = '{PT_LEFT,   PT_RIGHT,  PT_TOP,    PT_TOP};
         4'd13:   p = '{PT_TOP,    PT_RIGHT,  PT_TOP,    PT_TOP};
         4'd14:   p = '{PT_LEFT,   PT_TOP,    PT_TOP,    PT_TOP};
         default: p = '{PT_TOP,    PT_TOP,    PT_TOP,    PT_TOP};
      endcase
      return p;
   endfunction

endpackage

// ===== design/msq_line_buf.sv =====
module msq_line_buf (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [msq_pkg::COL_W-1:0] wr_addr,
   input  msq_pkg::corner_type       wr_data,
   input  logic [msq_pkg::COL_W-1:0] rd_addr,
   output msq_pkg::corner_type       rd_data
);
   import msq_pkg::*;

   corner_type line_mem_ff [MAX_GRID_WIDTH];
   corner_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= line_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/msq_edge_div.sv =====
module msq_edge_div (
   input  logic                  clock,
   input  logic                  reset,
   input  msq_pkg::div_ctrl_type ctrl,
   output msq_pkg::div_stat_type stat
);
   import msq_pkg::*;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   div_state_type          state_ff, state_in;
   logic [SAMPLE_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0]    den_ff, den_in;
   logic [FRAC_BITS-1:0]   quot_ff, quot_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic                   done_ff, done_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;

   logic signed [SAMPLE_W+1:0] num_s, den_s, num_abs, den_abs;
   logic [SAMPLE_W:0]          rem_x2, rem_diff;
   logic                       rem_ge;

   always_comb begin
      num_s = (SAMPLE_W+2)'($signed(ctrl.lv)) - (SAMPLE_W+2)'($signed(ctrl.a));
      den_s = (SAMPLE_W+2)'($signed(ctrl.b)) - (SAMPLE_W+2)'($signed(ctrl.a));
      if (den_s < 0) begin
         num_abs = -num_s;
         den_abs = -den_s;
      end else begin
         num_abs = num_s;
         den_abs = den_s;
      end
      rem_x2   = {rem_ff, 1'b0};
      rem_ge   = rem_x2 >= {1'b0, den_ff};
      rem_diff = rem_x2 - {1'b0, den_ff};
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      frac_in  = frac_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (ctrl.start) begin
               if (den_s == 0 || num_abs <= 0) begin
                  frac_in = '0;
                  done_in = 1'b1;
               end else if (num_abs >= den_abs) begin
                  frac_in = FRAC_ONE;
                  done_in = 1'b1;
               end else begin
                  rem_in   = num_abs[SAMPLE_W-1:0];
                  den_in   = den_abs[SAMPLE_W-1:0];
                  count_in = '0;
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            // restoring step, one quotient bit a cycle
            rem_in   = rem_ge ? rem_diff[SAMPLE_W-1:0] : rem_x2[SAMPLE_W-1:0];
            quot_in  = {quot_ff[FRAC_BITS-2:0], rem_ge};
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(FRAC_BITS - 1)) begin
               frac_in  = {1'b0, quot_ff[FRAC_BITS-2:0], rem_ge};
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      frac_ff  <= frac_in;
   end

   assign stat.busy = (state_ff == DIV_RUN);
   assign stat.done = done_ff;
   assign stat.frac = frac_ff;

endmodule

// ===== design/marching_squares_segments.sv =====
// channel  direction  handshake                payload
// req      in         req_tvalid / req_tready  tdata sample, tuser nan and frame start
// rsp      out        rsp_tvalid / rsp_tready  tdata segment end points, tlast last of cell
// csr      in         psel, penable, pready    level at 0x0, grid_width at 0x4
//
// an item whose cell gives no segment passes only the accept and line buffer read steps
// with segments, each edge of the cell goes in turn to the shared divider, which
// ends early when its fraction saturates, then the segments are emitted one by one,
// so a cell's time is set by the one restoring divider
// reset clears state, registers, counters, neighbors and rsp valid; the line buffer needs no clearing
// a stalled rsp holds the sequencer in its emit step; req is not ready meanwhile
module marching_squares_segments (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // sample
   input  logic [msq_pkg::REQ_DATA_W-1:0] req_tdata,
   // sample_nan, frame_start
   input  logic [msq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // from_row, from_col, to_row, to_col
   output logic [msq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [msq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [msq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [msq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import msq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FRAC,
      ST_EMIT
   } seq_state_type;

   seq_state_type     state_ff, state_in;

   // configuration
   sample_type        level_ff, level_in;
   logic [GRID_W-1:0] grid_width_ff, grid_width_in;

   // raster position and neighbors
   logic [COL_W-1:0]  col_count_ff, col_count_in;
   logic [ROW_W-1:0]  row_count_ff, row_count_in;
   corner_type        left_ff, left_in;
   corner_type        upper_left_ff, upper_left_in;

   // the item being worked on
   corner_type        cur_ff, cur_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   corner_type        ul_ff, ul_in, ur_ff, ur_in, ll_ff, ll_in, lr_ff, lr_in;
   logic [3:0]        sq_ff, sq_in;
   point_type         edge_ff, edge_in;
   logic              wait_ff, wait_in;
   logic [FRAC_W-1:0] frac_ff [4];
   logic [FRAC_W-1:0] frac_in [4];
   logic              seg_ff, seg_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // line buffer
   logic              mem_wr_en;
   logic [COL_W-1:0]  mem_rd_addr;
   corner_type        above;

   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;

   logic              accept;
   logic              csr_write;
   logic [GRID_W-1:0] width_eff;
   logic [3:0]        sq_now;
   logic              cell_ok;
   seg_pts_type       pts;
   point_type         pt_from, pt_to;
   logic              seg_last;
   logic [COORD_W-1:0] r0, c0, one;
   logic [COORD_W-1:0] pt_row [4];
   logic [COORD_W-1:0] pt_col [4];

   msq_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (col_ff),
      .wr_data (cur_ff),
      .rd_addr (mem_rd_addr),
      .rd_data (above)
   );

   msq_edge_div u_edge_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // frame start reads column zero
   assign mem_rd_addr = req_tuser[1] ? '0 : col_count_ff;

   // width in use, clamped to between 4 and what the line buffer holds
   always_comb begin
      if (grid_width_ff < GRID_W'(4)) begin
         width_eff = GRID_W'(4);
      end else if (grid_width_ff > GRID_W'(MAX_GRID_WIDTH)) begin
         width_eff = GRID_W'(MAX_GRID_WIDTH);
      end else begin
         width_eff = grid_width_ff;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[2])
         REG_LEVEL:      csr_prdata = CSR_DATA_W'(unsigned'(level_ff));
         REG_GRID_WIDTH: csr_prdata = CSR_DATA_W'(grid_width_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // case index of the cell closed by this item, corners as they stand in load
   always_comb begin
      sq_now[0] = $signed(upper_left_ff.value) > $signed(level_ff);
      sq_now[1] = $signed(above.value)         > $signed(level_ff);
      sq_now[2] = $signed(left_ff.value)       > $signed(level_ff);
      sq_now[3] = $signed(cur_ff.value)        > $signed(level_ff);
      cell_ok   = (row_ff != '0) && (col_ff != '0) &&
                  !(upper_left_ff.nan || above.nan || left_ff.nan || cur_ff.nan) &&
                  (seg_count(sq_now) != 2'd0);
   end

   // edge operands for the divider
   always_comb begin
      div_ctrl.start = (state_ff == ST_FRAC) && !wait_ff;
      div_ctrl.lv    = level_ff;
      unique case (edge_ff)
         PT_TOP:    begin div_ctrl.a = ul_ff.value; div_ctrl.b = ur_ff.value; end
         PT_BOTTOM: begin div_ctrl.a = ll_ff.value; div_ctrl.b = lr_ff.value; end
         PT_LEFT:   begin div_ctrl.a = ul_ff.value; div_ctrl.b = ll_ff.value; end
         PT_RIGHT:  begin div_ctrl.a = ur_ff.value; div_ctrl.b = lr_ff.value; end
         default:   begin div_ctrl.a = ul_ff.value; div_ctrl.b = ur_ff.value; end
      endcase
   end

   // crossing points in the image frame, wrapping at the coordinate width
   always_comb begin
      one = COORD_W'(FRAC_ONE);
      r0  = (COORD_W'(row_ff) - COORD_W'(2)) << FRAC_BITS;
      c0  = (COORD_W'(col_ff) - COORD_W'(2)) << FRAC_BITS;
      pt_row[PT_TOP]    = r0;
      pt_col[PT_TOP]    = c0 + COORD_W'(frac_ff[PT_TOP]);
      pt_row[PT_BOTTOM] = r0 + one;
      pt_col[PT_BOTTOM] = c0 + COORD_W'(frac_ff[PT_BOTTOM]);
      pt_row[PT_LEFT]   = r0 + COORD_W'(frac_ff[PT_LEFT]);
      pt_col[PT_LEFT]   = c0;
      pt_row[PT_RIGHT]  = r0 + COORD_W'(frac_ff[PT_RIGHT]);
      pt_col[PT_RIGHT]  = c0 + one;
      pts      = seg_table(sq_ff);
      pt_from  = seg_ff ? pts.from1 : pts.from0;
      pt_to    = seg_ff ? pts.to1   : pts.to0;
      seg_last = seg_ff || (seg_count(sq_ff) == 2'd1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      grid_width_in = grid_width_ff;
      col_count_in  = col_count_ff;
      row_count_in  = row_count_ff;
      left_in       = left_ff;
      upper_left_in = upper_left_ff;
      cur_in        = cur_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      ul_in         = ul_ff;
      ur_in         = ur_ff;
      ll_in         = ll_ff;
      lr_in         = lr_ff;
      sq_in         = sq_ff;
      edge_in       = edge_ff;
      wait_in       = wait_ff;
      frac_in       = frac_ff;
      seg_in        = seg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;

      if (csr_write) begin
         if (csr_paddr[2] == REG_GRID_WIDTH) begin
            grid_width_in = csr_pwdata[GRID_W-1:0];
         end else begin
            level_in = csr_pwdata[SAMPLE_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in.value = req_tdata[SAMPLE_W-1:0];
               cur_in.nan   = req_tuser[0];
               // frame start puts this item at padded row 0, column 0
               col_in   = req_tuser[1] ? '0 : col_count_ff;
               row_in   = req_tuser[1] ? '0 : row_count_ff;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // line buffer data is valid now; shift neighbors and store this item
            ul_in         = upper_left_ff;
            ur_in         = above;
            ll_in         = left_ff;
            lr_in         = cur_ff;
            upper_left_in = above;
            left_in       = cur_ff;
            mem_wr_en     = 1'b1;
            if ({1'b0, col_ff} + 1'b1 >= width_eff) begin
               col_count_in = '0;
               row_count_in = (row_ff == ROW_MAX) ? row_ff : row_ff + 1'b1;
            end else begin
               col_count_in = col_ff + 1'b1;
               row_count_in = row_ff;
            end
            if (cell_ok) begin
               sq_in    = sq_now;
               edge_in  = PT_TOP;
               wait_in  = 1'b0;
               state_in = ST_FRAC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FRAC: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end
            if (div_stat.done) begin
               frac_in[edge_ff] = div_stat.frac;
               wait_in          = 1'b0;
               unique case (edge_ff)
                  PT_TOP:    edge_in = PT_BOTTOM;
                  PT_BOTTOM: edge_in = PT_LEFT;
                  PT_LEFT:   edge_in = PT_RIGHT;
                  PT_RIGHT: begin
                     seg_in   = 1'b0;
                     state_in = ST_EMIT;
                  end
                  default:   edge_in = PT_TOP;
               endcase
            end
         end
         ST_EMIT: begin
            // load the output register once it is free or being taken
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pt_col[pt_to], pt_row[pt_to],
                               pt_col[pt_from], pt_row[pt_from]};
               rsp_last_in  = seg_last;
               if (seg_last) begin
                  state_in = ST_IDLE;
               end else begin
                  seg_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         level_ff      <= '0;
         grid_width_ff <= GRID_W'(MAX_GRID_WIDTH);
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         left_ff       <= '0;
         upper_left_ff <= '0;
         wait_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         grid_width_ff <= grid_width_in;
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
         left_ff       <= left_in;
         upper_left_ff <= upper_left_in;
         wait_ff       <= wait_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      ul_ff       <= ul_in;
      ur_ff       <= ur_in;
      ll_ff       <= ll_in;
      lr_ff       <= lr_in;
      sq_ff       <= sq_in;
      edge_ff     <= edge_in;
      frac_ff     <= frac_in;
      seg_ff      <= seg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // no item is taken while the divider is still iterating
   a_accept_div_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !div_stat.busy)
      else $error("item accepted while divider busy");

   // a divider result only arrives for a request issued from the edge step
   a_done_in_frac: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_FRAC) && wait_ff)
      else $error("divider result outside edge step");

   // a second segment only for saddle cells
   a_second_seg_saddle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && seg_ff |-> seg_count(sq_ff) == 2'd2)
      else $error("second segment on a non-saddle cell");

   // fractions stay within one cell edge
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (frac_ff[0] <= FRAC_ONE) && (frac_ff[1] <= FRAC_ONE) &&
                                (frac_ff[2] <= FRAC_ONE) && (frac_ff[3] <= FRAC_ONE))
      else $error("edge fraction above one");

   // the last segment of a cell returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready) && seg_last
      |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after last segment");
`endif

endmodule

// ===== bench/marching_squares_segments_tb.sv =====
module marching_squares_segments_tb;

   import msq_pkg::*;

   localparam int CELL_SETTLE = 60;
   localparam int RANDOM_ITEMS = 1400;
   localparam longint FRAC_UNIT = longint'(1) << FRAC_BITS;
   localparam int ROW_LIMIT = 8191;

   // padded 5x4 grid: saddle 9, saddle 6, a nan corner, extremes of the sample range
   localparam logic [15:0] DEMO_GRID [20] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h7FFF, 16'h8000, 16'h0000,
      16'h0000, 16'h8000, 16'h7FFF, 16'h0000,
      16'h0000, 16'h0100, 16'hFF00, 16'h0000,
      16'h0000, 16'h7FFF, 16'h0001, 16'h0000
   };
   localparam int DEMO_NAN_POS = 17;

   typedef struct packed {
      logic        fs;
      logic        nan;
      logic [15:0] value;
   } grid_sample_t;

   // packed from the top down, so from_row lands in the lowest tdata bits
   typedef struct packed {
      logic [COORD_W-1:0] to_col;
      logic [COORD_W-1:0] to_row;
      logic [COORD_W-1:0] from_col;
      logic [COORD_W-1:0] from_row;
   } seg_coords_t;

   typedef struct packed {
      seg_coords_t xy;
      logic        last;
   } segment_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // sample
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // sample_nan, frame_start
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // from_row, from_col, to_row, to_col
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   marching_squares_segments i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow of the block: line buffer, neighbors, counters, registers
   // ---------------------------------------------------------------------
   corner_type        line_store [MAX_GRID_WIDTH];
   corner_type        west;
   corner_type        northwest;
   int                row_pos;
   int                col_pos;
   logic [15:0]       iso_level;
   logic [GRID_W-1:0] width_reg;

   grid_sample_t samples_to_send [$];
   segment_t     segments_due [$];

   int     error_count = 0;
   int     items_pushed = 0;
   longint cycle_count = 0;
   logic   steady = 1'b0;     // phase with no gaps and no stalls
   int     send_gap = 0;
   int     stall_left = 0;
   grid_sample_t next_item;
   seg_coords_t  got_xy;
   segment_t     want_seg;

   // width register clamped to the range the line buffer supports
   function automatic int usable_width(input logic [GRID_W-1:0] gw);
      if (gw < 4) return 4;
      if (gw > MAX_GRID_WIDTH) return MAX_GRID_WIDTH;
      return int'(gw);
   endfunction

   // where the level crosses edge a..b, as a fraction of the edge, clipped to [0, 1]
   function automatic longint crossing(input longint a, input longint b, input longint lv);
      longint num;
      longint den;
      num = lv - a;
      den = b - a;
      if (den == 0) return 0;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num <= 0) return 0;
      if (num >= den) return FRAC_UNIT;
      return (num * FRAC_UNIT) / den;
   endfunction

   // one sample in, zero to two segments queued
   task automatic march_sample(input logic [15:0] raw, input logic nan_in, input logic fs_in);
      corner_type here;
      corner_type above;
      int         col;
      int         w;
      int         n;
      logic [3:0] sq;
      longint     lv, vul, vur, vll, vlr, r0, c0;
      longint     pr [4];
      longint     pc [4];
      point_type  ends [4];
      segment_t   seg;
      here.nan = nan_in;
      here.value = raw;
      w = usable_width(width_reg);
      if (fs_in) begin
         row_pos = 0;
         col_pos = 0;
      end
      col = col_pos;
      above = line_store[col];

      // corners: ul = northwest, ur = above, ll = west, lr = here
      if (row_pos >= 1 && col >= 1 &&
          !(northwest.nan || above.nan || west.nan || here.nan)) begin
         lv  = longint'($signed(iso_level));
         vul = longint'($signed(northwest.value));
         vur = longint'($signed(above.value));
         vll = longint'($signed(west.value));
         vlr = longint'($signed(here.value));
         sq = {vlr > lv, vll > lv, vur > lv, vul > lv};
         n = (sq == 4'd0 || sq == 4'd15) ? 0 : (sq == 4'd6 || sq == 4'd9) ? 2 : 1;
         case (sq)
            4'd1:    ends = '{PT_TOP,    PT_LEFT,   PT_TOP,    PT_TOP};
            4'd2:    ends = '{PT_RIGHT,  PT_TOP,    PT_TOP,    PT_TOP};
            4'd3:    ends = '{PT_RIGHT,  PT_LEFT,   PT_TOP,    PT_TOP};
            4'd4:    ends = '{PT_LEFT,   PT_BOTTOM, PT_TOP,    PT_TOP};
            4'd5:    ends = '{PT_TOP,    PT_BOTTOM, PT_TOP,    PT_TOP};
            // saddles keep the low corners connected
            4'd6:    ends = '{PT_RIGHT,  PT_TOP,    PT_LEFT,   PT_BOTTOM};
            4'd7:    ends = '{PT_RIGHT,  PT_BOTTOM, PT_TOP,    PT_TOP};
            4'd8:    ends = '{PT_BOTTOM, PT_RIGHT,  PT_TOP,    PT_TOP};
            4'd9:    ends = '{PT_TOP,    PT_LEFT,   PT_BOTTOM, PT_RIGHT};
            4'd10:   ends = '{PT_BOTTOM, PT_TOP,    PT_TOP,    PT_TOP};
            4'd11:   ends = '{PT_BOTTOM, PT_LEFT,   PT_TOP,    PT_TOP};
            4'd12:   ends = '{PT_LEFT,   PT_RIGHT,  PT_TOP,    PT_TOP};
            4'd13:   ends = '{PT_TOP,    PT_RIGHT,  PT_TOP,    PT_TOP};
            4'd14:   ends = '{PT_LEFT,   PT_TOP,    PT_TOP,    PT_TOP};
            default: ends = '{PT_TOP,    PT_TOP,    PT_TOP,    PT_TOP};
         endcase
         // padded position p is image position p - 1, the cell's corner one further back
         r0 = (longint'(row_pos) - 2) * FRAC_UNIT;
         c0 = (longint'(col) - 2) * FRAC_UNIT;
         pr[PT_TOP]    = r0;
         pc[PT_TOP]    = c0 + crossing(vul, vur, lv);
         pr[PT_BOTTOM] = r0 + FRAC_UNIT;
         pc[PT_BOTTOM] = c0 + crossing(vll, vlr, lv);
         pr[PT_LEFT]   = r0 + crossing(vul, vll, lv);
         pc[PT_LEFT]   = c0;
         pr[PT_RIGHT]  = r0 + crossing(vur, vlr, lv);
         pc[PT_RIGHT]  = c0 + FRAC_UNIT;
         for (int k = 0; k < n; k++) begin
            seg.xy.from_row = COORD_W'(pr[ends[2*k]]);
            seg.xy.from_col = COORD_W'(pc[ends[2*k]]);
            seg.xy.to_row   = COORD_W'(pr[ends[2*k+1]]);
            seg.xy.to_col   = COORD_W'(pc[ends[2*k+1]]);
            seg.last        = (k == n - 1);
            segments_due = {segments_due, seg};
         end
      end

      northwest = above;
      west = here;
      line_store[col] = here;
      // a column past a freshly lowered width wraps right after this sample
      if (col + 1 >= w) begin
         col_pos = 0;
         if (row_pos < ROW_LIMIT) row_pos++;
      end else begin
         col_pos = col + 1;
      end
   endtask

   // ---------------------------------------------------------------------
   // random choices
   // ---------------------------------------------------------------------
   // mostly back to back, some short gaps, now and then a long one
   function automatic int pick_gap();
      int k;
      if (steady) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_level();
      int k;
      k = $urandom_range(0, 99);
      if (k < 12) return 16'h8000;
      if (k < 24) return 16'h7FFF;
      if (k < 40) return 16'($urandom);
      return 16'($urandom_range(0, 2047)) - 16'd1024;
   endfunction

   // values cluster around the level so crossings are common
   function automatic logic [15:0] pick_sample(input logic [15:0] lv);
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return lv + 16'($urandom_range(0, 1200)) - 16'd600;
      if (k < 75) return 16'($urandom);
      if (k < 85) return 16'h7FFF;
      if (k < 95) return 16'h8000;
      return lv;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_item(input logic [15:0] value, input logic nan, input logic fs);
      grid_sample_t s;
      s.value = value;
      s.nan = nan;
      s.fs = fs;
      samples_to_send = {samples_to_send, s};
      items_pushed++;
   endtask

   // well-formed padded frame, cut short after keep items
   task automatic push_frame(input int rows, input int w, input int keep);
      int   count;
      logic pad;
      count = 0;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < w; c++) begin
            if (count < keep) begin
               pad = (r == 0 || r == rows - 1 || c == 0 || c == w - 1);
               push_item(pad ? 16'h0000 : pick_sample(iso_level),
                         !pad && $urandom_range(0, 39) == 0, r == 0 && c == 0);
            end
            count++;
         end
      end
   endtask

   // nothing queued, nothing on the bus, nothing owed, then let the last cell finish
   task automatic wait_until_drained();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_tvalid || segments_due.size() != 0);
      repeat (CELL_SETTLE) @(negedge clock);
   endtask

   // setup cycle, access cycle; the register takes the value at the access edge
   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_sel == REG_LEVEL) iso_level = data[15:0];
      else width_reg = data[GRID_W-1:0];
   endtask

   task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
                                input logic [COORD_W-1:0] got);
      if (want !== got) begin
         if (error_count < 60)
            $display("%0t rsp %s: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: one item from the queue, after any random gap, whenever the slot is free
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (samples_to_send.size() != 0) begin
            next_item = samples_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.value;
            req_tuser  <= {next_item.fs, next_item.nan};
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predicts on every accepted item, checks every accepted segment,
   // and stalls the result side at random
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            march_sample(req_tdata, req_tuser[0], req_tuser[1]);

         if (rsp_tvalid && rsp_tready) begin
            got_xy = rsp_tdata;
            if (segments_due.size() == 0) begin
               if (error_count < 60)
                  $display("%0t rsp segment: expected none, actual %h last %b",
                           $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want_seg = segments_due.pop_front();
               compare_field("from_row", want_seg.xy.from_row, got_xy.from_row);
               compare_field("from_col", want_seg.xy.from_col, got_xy.from_col);
               compare_field("to_row", want_seg.xy.to_row, got_xy.to_row);
               compare_field("to_col", want_seg.xy.to_col, got_xy.to_col);
               compare_field("last", COORD_W'(want_seg.last), COORD_W'(rsp_tlast));
            end
         end

         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 6) == 0) stall_left = pick_gap();
         end
      end
   end

   // watchdog, scaled by the amount of stimulus so far
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 20000 + 1000 * longint'(items_pushed)) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // phases
   // ---------------------------------------------------------------------
   initial begin
      int          k, rows, frames, w, keep, n_items, random_base;
      logic [15:0] lv;
      logic [12:0] gw;
      logic        need_fs;

      for (int i = 0; i < MAX_GRID_WIDTH; i++) line_store[i] = '0;
      west = '0;
      northwest = '0;
      row_pos = 0;
      col_pos = 0;
      iso_level = '0;
      width_reg = 13'd4096;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: saddles, nan corner, field extremes, then a new frame start
      csr_write(REG_LEVEL, 32'h0);
      csr_write(REG_GRID_WIDTH, 32'd4);
      for (int i = 0; i < 20; i++) push_item(DEMO_GRID[i], i == DEMO_NAN_POS, i == 0);
      push_item(16'h1234, 1'b0, 1'b1);

      // random phases, each under its own settings
      random_base = items_pushed;
      while (items_pushed - random_base < RANDOM_ITEMS) begin
         wait_until_drained();
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            lv = pick_level();
            csr_write(REG_LEVEL, {16'h0, lv});
         end
         need_fs = 1'b0;
         if ($urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, 99);
            if (k < 10) gw = 13'($urandom_range(0, 3));
            else if (k < 40) gw = 13'($urandom_range(4, 6));
            else gw = 13'($urandom_range(7, 24));
            // a wider grid would reach line buffer entries never written this frame
            need_fs = usable_width(gw) > usable_width(width_reg);
            csr_write(REG_GRID_WIDTH, {19'h0, gw});
         end
         w = usable_width(width_reg);

         if (need_fs || $urandom_range(0, 9) < 7) begin
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
               rows = $urandom_range(3, 8);
               keep = rows * w;
               // a broken frame leaves the next phase mid-row
               if (f == frames - 1 && $urandom_range(0, 3) == 0)
                  keep = $urandom_range(1, rows * w);
               push_frame(rows, w, keep);
            end
         end else begin
            // loose items: stray frame starts, frequent nans, no padding
            n_items = $urandom_range(10, 60);
            for (int i = 0; i < n_items; i++)
               push_item($urandom_range(0, 1) ? pick_sample(iso_level) : 16'($urandom),
                         $urandom_range(0, 9) == 0,
                         (i == 0 && need_fs) || $urandom_range(0, 24) == 0);
         end
      end

      // oversized width register clamps to the line buffer depth; a short first row
      wait_until_drained();
      steady = 1'b0;
      csr_write(REG_GRID_WIDTH, 32'd8191);
      csr_write(REG_LEVEL, {16'h0, pick_level()});
      for (int c = 0; c < 40; c++) push_item(pick_sample(iso_level), 1'b0, c == 0);

      wait_until_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/msq_pkg.sv
design/msq_line_buf.sv
design/msq_edge_div.sv
design/marching_squares_segments.sv
bench/marching_squares_segments_tb.sv
